// ===== rtl/core/mhpq_pkg.sv =====
package mhpq_pkg;

	localparam int HEAP_DEPTH = 1024;
	localparam int DATA_W     = 32;
	localparam int CAP_W      = 11;
	localparam int CNT_OUT_W  = 11;
	localparam int STATUS_W   = 2;
	localparam int LEVELS     = $clog2(HEAP_DEPTH + 1);
	localparam int NODE_W     = LEVELS;
	localparam int REM_W      = $clog2(LEVELS);
	localparam int ROW_W      = 2 * DATA_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

	localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(2);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		TK_INS,
		TK_FETCH,
		TK_SIFT
	} tok_kind_t;

	// token that walks down the level chain; nd is the 1-based heap node number
	typedef struct packed {
		logic              act;
		tok_kind_t         kind;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] aux;
		logic [NODE_W-1:0] nd;
		logic [NODE_W-1:0] q;
		logic [REM_W-1:0]  rem;
		logic [NODE_W-1:0] n;
	} tok_t;

	typedef struct packed {
		logic [1:0]        we;
		logic [NODE_W-1:0] nd;
		logic [ROW_W-1:0]  data;
	} wr_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] aux;
	} rep_t;

	// level of a 1-based node number: index of its top set bit
	function automatic logic [REM_W-1:0] top_level(input logic [NODE_W-1:0] q);
		logic [REM_W-1:0] r;
		r = '0;
		for (int i = 0; i < NODE_W; i++) begin
			if (q[i]) begin
				r = REM_W'(i);
			end
		end
		return r;
	endfunction

	// rows of two entries needed by one level
	function automatic int level_rows(input int k);
		int lo;
		int nodes;
		lo    = 1 << k;
		nodes = HEAP_DEPTH - lo + 1;
		if (nodes > lo) begin
			nodes = lo;
		end
		return (nodes + 1) >> 1;
	endfunction

	function automatic int level_aw(input int k);
		int rows;
		rows = level_rows(k);
		return (rows <= 2) ? 1 : $clog2(rows);
	endfunction

endpackage

// ===== rtl/core/mhpq_ram.sv =====
module mhpq_ram #(
	parameter int ROWS   = 2,
	parameter int AW     = 1,
	parameter int LANE_W = 32
) (
	input  logic                  clk,
	input  logic [1:0]            we,
	input  logic [AW-1:0]         waddr,
	input  logic [2*LANE_W-1:0]   wdata,
	input  logic [AW-1:0]         raddr,
	output logic [2*LANE_W-1:0]   rdata
);

	logic [2*LANE_W-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (we[0]) begin
			mem[waddr][LANE_W-1:0] <= wdata[LANE_W-1:0];
		end
		if (we[1]) begin
			mem[waddr][2*LANE_W-1:LANE_W] <= wdata[2*LANE_W-1:LANE_W];
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/mhpq_cell.sv =====
module mhpq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mhpq_pkg::tok_t                tok_in,
	input  logic [mhpq_pkg::ROW_W-1:0]    rd_data,
	output logic [mhpq_pkg::NODE_W-1:0]   rd_nd,
	output mhpq_pkg::wr_t                 wr,
	output mhpq_pkg::wr_t                 wb,
	output mhpq_pkg::tok_t                tok_out,
	output mhpq_pkg::rep_t                rep
);

	import mhpq_pkg::*;

	tok_t              tok_s1;
	tok_t              tok_q;
	tok_t              nxt;
	logic [DATA_W-1:0] lane0;
	logic [DATA_W-1:0] lane1;
	logic [DATA_W-1:0] x;
	logic [DATA_W-1:0] cmax;
	logic [NODE_W:0]   right_num;
	logic [NODE_W:0]   grand;
	logic [NODE_W-1:0] child;
	logic [NODE_W-1:0] parent;
	logic              rv;
	logic              pick;
	logic              has_kids;

	// entry cycle: read this level's row at the token's node
	assign rd_nd = tok_in.nd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_q  <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_q  <= nxt;
		end
	end

	assign tok_out = tok_q;

	always_comb begin
		lane0     = rd_data[DATA_W-1:0];
		lane1     = rd_data[ROW_W-1:DATA_W];
		x         = tok_s1.nd[0] ? lane1 : lane0;
		// sift: nd is the left child of the hole, so lane 0 is left and lane 1 right
		right_num = {1'b0, tok_s1.nd} + 1'b1;
		rv        = right_num <= {1'b0, tok_s1.n};
		pick      = rv && !($signed(lane1) < $signed(lane0));
		cmax      = pick ? lane1 : lane0;
		child     = tok_s1.nd | NODE_W'(pick);
		grand     = {child, 1'b0};
		has_kids  = grand <= {1'b0, tok_s1.n};
		parent    = tok_s1.nd >> 1;

		nxt     = tok_s1;
		nxt.act = 1'b0;
		wr      = '0;
		wb      = '0;
		rep     = '0;

		if (tok_s1.act) begin
			case (tok_s1.kind)
				TK_INS: begin
					wr.nd   = tok_s1.nd;
					wr.data = {tok_s1.v, tok_s1.v};
					if (tok_s1.rem == '0) begin
						wr.we    = tok_s1.nd[0] ? 2'b10 : 2'b01;
						rep.done = 1'b1;
					end else begin
						nxt.act = 1'b1;
						nxt.rem = tok_s1.rem - 1'b1;
						nxt.nd  = tok_s1.q >> (tok_s1.rem - 1'b1);
						// larger value takes the node, the smaller one moves on down
						if ($signed(x) < $signed(tok_s1.v)) begin
							wr.we = tok_s1.nd[0] ? 2'b10 : 2'b01;
							nxt.v = x;
						end
					end
				end
				TK_FETCH: begin
					if (tok_s1.nd == NODE_W'(1)) begin
						nxt.aux = x;
					end
					if (tok_s1.rem == '0) begin
						rep.done = 1'b1;
						rep.data = x;
						rep.aux  = nxt.aux;
					end else begin
						nxt.act = 1'b1;
						nxt.rem = tok_s1.rem - 1'b1;
						nxt.nd  = tok_s1.q >> (tok_s1.rem - 1'b1);
					end
				end
				TK_SIFT: begin
					wb.nd = parent;
					wb.we = parent[0] ? 2'b10 : 2'b01;
					if ($signed(tok_s1.v) < $signed(cmax)) begin
						wb.data = {cmax, cmax};
						if (has_kids) begin
							nxt.act = 1'b1;
							nxt.nd  = grand[NODE_W-1:0];
						end else begin
							// hole ends on this level: drop the carried value in
							wr.nd    = child;
							wr.data  = {tok_s1.v, tok_s1.v};
							wr.we    = pick ? 2'b10 : 2'b01;
							rep.done = 1'b1;
						end
					end else begin
						wb.data  = {tok_s1.v, tok_s1.v};
						rep.done = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/mhpq_ctrl.sv =====
module mhpq_ctrl (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  operation,
	input  logic signed [mhpq_pkg::DATA_W-1:0]    value,
	output logic                                  done,
	output logic signed [mhpq_pkg::DATA_W-1:0]    max_value,
	output logic [mhpq_pkg::STATUS_W-1:0]         status,
	output logic [mhpq_pkg::CNT_OUT_W-1:0]        entry_count,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mhpq_pkg::CAP_W-1:0]            capacity_limit,
	input  mhpq_pkg::rep_t                        rep,
	output mhpq_pkg::tok_t                        launch,
	output mhpq_pkg::tok_t                        sift
);

	import mhpq_pkg::*;

	localparam int CMP_W = (CAP_W > NODE_W) ? CAP_W : NODE_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_INS   = 4'b0010,
		S_FETCH = 4'b0100,
		S_SIFT  = 4'b1000
	} state_t;

	state_t                state_q, state_d;
	logic [NODE_W-1:0]     count_q, count_d;
	logic [CAP_W-1:0]      cap_q;
	tok_t                  launch_q, launch_d;
	tok_t                  sift_q, sift_d;
	logic                  done_q, done_d;
	logic [DATA_W-1:0]     max_q, max_d;
	logic [STATUS_W-1:0]   status_q, status_d;
	logic [CNT_OUT_W-1:0]  cnt_out_q, cnt_out_d;
	logic [DATA_W-1:0]     root_q, root_d;
	logic [CMP_W-1:0]      cap_ext;
	logic [CMP_W-1:0]      depth_ext;
	logic [CMP_W-1:0]      limit;
	logic [NODE_W-1:0]     count_inc;
	logic [NODE_W-1:0]     count_dec;

	always_comb begin
		cap_ext   = CMP_W'(cap_q);
		depth_ext = CMP_W'(HEAP_DEPTH);
		limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
		count_inc = count_q + 1'b1;
		count_dec = count_q - 1'b1;
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		done_d       = 1'b0;
		max_d        = max_q;
		status_d     = status_q;
		cnt_out_d    = cnt_out_q;
		root_d       = root_q;
		launch_d     = launch_q;
		launch_d.act = 1'b0;
		sift_d       = sift_q;
		sift_d.act   = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (operation == OP_INSERT) begin
						if (CMP_W'(count_q) >= limit) begin
							done_d    = 1'b1;
							max_d     = '0;
							status_d  = ST_FULL;
							cnt_out_d = CNT_OUT_W'(count_q);
						end else begin
							launch_d = '{act: 1'b1, kind: TK_INS, v: value, aux: '0,
								nd: NODE_W'(1), q: count_inc, rem: top_level(count_inc),
								n: count_q};
							state_d  = S_INS;
						end
					end else begin
						if (count_q == '0) begin
							done_d    = 1'b1;
							max_d     = '0;
							status_d  = ST_EMPTY;
							cnt_out_d = CNT_OUT_W'(count_q);
						end else begin
							// first pass reads the root and the last entry
							launch_d = '{act: 1'b1, kind: TK_FETCH, v: '0, aux: '0,
								nd: NODE_W'(1), q: count_q, rem: top_level(count_q),
								n: count_q};
							state_d  = S_FETCH;
						end
					end
				end
			end
			S_INS: begin
				if (rep.done) begin
					count_d   = count_inc;
					done_d    = 1'b1;
					max_d     = '0;
					status_d  = ST_OK;
					cnt_out_d = CNT_OUT_W'(count_inc);
					state_d   = S_IDLE;
				end
			end
			S_FETCH: begin
				if (rep.done) begin
					root_d  = rep.aux;
					count_d = count_dec;
					if (count_dec == '0) begin
						done_d    = 1'b1;
						max_d     = rep.aux;
						status_d  = ST_OK;
						cnt_out_d = '0;
						state_d   = S_IDLE;
					end else begin
						// last entry fills the root hole and sifts down from level one
						sift_d  = '{act: 1'b1, kind: TK_SIFT, v: rep.data, aux: '0,
							nd: NODE_W'(2), q: '0, rem: '0, n: count_dec};
						state_d = S_SIFT;
					end
				end
			end
			S_SIFT: begin
				if (rep.done) begin
					done_d    = 1'b1;
					max_d     = root_q;
					status_d  = ST_OK;
					cnt_out_d = CNT_OUT_W'(count_q);
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cap_q    <= CAP_RESET;
			done_q   <= 1'b0;
			launch_q <= '0;
			sift_q   <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			done_q   <= done_d;
			launch_q <= launch_d;
			sift_q   <= sift_d;
			if (cfg_valid) begin
				cap_q <= capacity_limit;
			end
		end
	end

	always_ff @(posedge clk) begin
		max_q     <= max_d;
		status_q  <= status_d;
		cnt_out_q <= cnt_out_d;
		root_q    <= root_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign max_value   = max_q;
	assign status      = status_q;
	assign entry_count = cnt_out_q;
	assign launch      = launch_q;
	assign sift        = sift_q;

endmodule

// ===== rtl/core/max_heap_priority_queue_core.sv =====
// A refused insert or remove answers in the cycle after start; done is registered.
// Insert: one pass down to D, the heap level of the new entry (D at most 10).
// Remove: a fetch pass down to D, the level of the last entry, then a sift from
// level one to E, where the sift ends; one read and one compare per level cell.
// One item at a time: busy is high until the result strobe; the receiver cannot stall.
// Reset clears the count and sets the capacity to 1024; heap storage is not cleared.
module max_heap_priority_queue_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  operation,
	input  logic signed [mhpq_pkg::DATA_W-1:0]    value,
	output logic                                  done,
	output logic signed [mhpq_pkg::DATA_W-1:0]    max_value,
	output logic [mhpq_pkg::STATUS_W-1:0]         status,
	output logic [mhpq_pkg::CNT_OUT_W-1:0]        entry_count,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mhpq_pkg::CAP_W-1:0]            capacity_limit
);

	import mhpq_pkg::*;

	tok_t              launch;
	tok_t              sift;
	rep_t              rep_all;
	tok_t              tok_in  [LEVELS];
	tok_t              tok_out [LEVELS];
	wr_t               wr      [LEVELS];
	wr_t               wb      [LEVELS];
	rep_t              rep     [LEVELS];
	logic [NODE_W-1:0] rd_nd   [LEVELS];
	logic [ROW_W-1:0]  rd_data [LEVELS];

	mhpq_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.value          (value),
		.done           (done),
		.max_value      (max_value),
		.status         (status),
		.entry_count    (entry_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_limit (capacity_limit),
		.rep            (rep_all),
		.launch         (launch),
		.sift           (sift)
	);

	// only one cell reports at a time
	always_comb begin
		rep_all = '0;
		for (int k = 0; k < LEVELS; k++) begin
			rep_all = rep_t'(rep_all | rep[k]);
		end
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_level
		localparam int                ROWS = level_rows(k);
		localparam int                AW   = level_aw(k);
		localparam logic [NODE_W-1:0] BASE = NODE_W'(1) << k;

		wr_t           wsel;
		logic [AW-1:0] waddr;
		logic [AW-1:0] raddr;

		if (k == 0) begin : g_head
			assign tok_in[k] = launch;
		end else if (k == 1) begin : g_sift_entry
			assign tok_in[k] = sift.act ? sift : tok_out[k-1];
		end else begin : g_link
			assign tok_in[k] = tok_out[k-1];
		end

		// this level is written by its own cell or by the cell below moving the hole
		if (k < LEVELS - 1) begin : g_wsel
			assign wsel = (wb[k+1].we != 2'b00) ? wb[k+1] : wr[k];
		end else begin : g_wlast
			assign wsel = wr[k];
		end

		assign waddr = AW'((wsel.nd ^ BASE) >> 1);
		assign raddr = AW'((rd_nd[k] ^ BASE) >> 1);

		mhpq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_in[k]),
			.rd_data (rd_data[k]),
			.rd_nd   (rd_nd[k]),
			.wr      (wr[k]),
			.wb      (wb[k]),
			.tok_out (tok_out[k]),
			.rep     (rep[k])
		);

		mhpq_ram #(
			.ROWS   (ROWS),
			.AW     (AW),
			.LANE_W (DATA_W)
		) u_ram (
			.clk   (clk),
			.we    (wsel.we),
			.waddr (waddr),
			.wdata (wsel.data),
			.raddr (raddr),
			.rdata (rd_data[k])
		);
	end

endmodule

// ===== rtl/core/mhpq_chk.sv =====
module mhpq_chk (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic                                  done,
	input  logic signed [mhpq_pkg::DATA_W-1:0]    max_value,
	input  logic [mhpq_pkg::STATUS_W-1:0]         status,
	input  logic [mhpq_pkg::CNT_OUT_W-1:0]        entry_count
);

	import mhpq_pkg::*;

	// a transfer in is either answered at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither answered nor busy");

	a_done_at_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (max_value == '0))
		else $error("refused operation returned a nonzero value");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (entry_count == '0))
		else $error("empty remove with nonzero count");

endmodule

bind max_heap_priority_queue_core mhpq_chk u_mhpq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.max_value   (max_value),
	.status      (status),
	.entry_count (entry_count)
);
